// File: design/nmsh_pkg.sv
`default_nettype none

package nmsh_pkg;

  localparam logic [31:0] MixC1   = 32'hcc9e2d51;
  localparam logic [31:0] MixC2   = 32'h1b873593;
  localparam logic [31:0] MixAdd  = 32'he6546b64;
  localparam logic [31:0] FinM1   = 32'h85ebca6b;
  localparam logic [31:0] FinM2   = 32'hc2b2ae35;
  localparam logic [7:0]  AsciiZero = 8'h30;
  localparam logic [7:0]  AsciiNine = 8'h39;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_IDLE   = 4'd0,
    OP_ABSORB = 4'd1,  // take one request (byte or empty string)
    OP_K1     = 4'd2,  // w *= C1
    OP_K2     = 4'd3,  // w = rotl15(w) * C2
    OP_KMIX   = 4'd4,  // h = rotl13(h ^ w) * 5 + add
    OP_KTAIL  = 4'd5,  // h ^= w
    OP_F1     = 4'd6,  // w = fmix step 1 (xor-shift 16, * M1)
    OP_F2     = 4'd7,  // w = fmix step 2 (xor-shift 13, * M2)
    OP_RESULT = 4'd8   // load output register
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic block_done;   // absorbed byte completes a 4-byte block
    logic digits_next;  // all bytes including this one are digits
    logic all_digits;   // current all-digits flag
  } status_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

endpackage

`default_nettype wire

// File: design/nmsh_datapath.sv
`default_nettype none

module nmsh_datapath (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  nmsh_pkg::cmd_t   cmd_i,
  input  wire [7:0]        data_byte_i,
  input  wire              last_byte_i,
  input  wire              empty_string_i,
  input  wire [31:0]       seed_i,
  output nmsh_pkg::status_t status_o,
  output logic [31:0]      hash_value_o,
  output logic             was_number_o
);

  logic [31:0] hash_q, hash_d;
  logic [23:0] part_q, part_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] len_q, len_d;
  logic [31:0] dec_q, dec_d;
  logic        alld_q, alld_d;
  logic [31:0] seed_q, seed_d;
  logic        instr_q, instr_d;
  logic [31:0] work_q, work_d;
  logic [31:0] res_q, res_d;
  logic        num_q, num_d;

  // start-of-string view of the state
  logic [31:0] hash_b, len_b, dec_b;
  logic [23:0] part_b, part_n;
  logic [1:0]  phase_b;
  logic        alld_b, is_digit;
  logic [31:0] mul_a, mul_b, fin_x, mix_t;
  logic [63:0] prod;

  assign is_digit = (data_byte_i >= nmsh_pkg::AsciiZero) && (data_byte_i <= nmsh_pkg::AsciiNine);

  always_comb begin
    if (instr_q) begin
      hash_b = hash_q; part_b = part_q; phase_b = phase_q;
      len_b = len_q; dec_b = dec_q; alld_b = alld_q;
    end else begin
      hash_b = seed_i; part_b = '0; phase_b = '0;
      len_b = '0; dec_b = '0; alld_b = 1'b1;
    end
  end

  assign status_o.block_done  = (phase_b == 2'd3);
  assign status_o.digits_next = alld_b & is_digit;
  assign status_o.all_digits  = alld_q;

  always_comb begin
    part_n = part_b;
    unique case (phase_b)
      2'd0:    part_n[7:0]   = data_byte_i;
      2'd1:    part_n[15:8]  = data_byte_i;
      2'd2:    part_n[23:16] = data_byte_i;
      default: part_n        = part_b;
    endcase
  end

  // shared 32x32 multiplier, low word kept
  assign fin_x = hash_q ^ len_q;
  always_comb begin
    unique case (cmd_i.op)
      nmsh_pkg::OP_K1: begin
        mul_a = work_q; mul_b = nmsh_pkg::MixC1;
      end
      nmsh_pkg::OP_K2: begin
        mul_a = nmsh_pkg::rotl15(work_q); mul_b = nmsh_pkg::MixC2;
      end
      nmsh_pkg::OP_F1: begin
        mul_a = fin_x ^ (fin_x >> 16); mul_b = nmsh_pkg::FinM1;
      end
      nmsh_pkg::OP_F2: begin
        mul_a = work_q ^ (work_q >> 13); mul_b = nmsh_pkg::FinM2;
      end
      default: begin
        mul_a = work_q; mul_b = nmsh_pkg::MixC1;
      end
    endcase
  end
  assign prod  = mul_a * mul_b;
  assign mix_t = nmsh_pkg::rotl13(hash_q ^ work_q);

  always_comb begin
    hash_d = hash_q; part_d = part_q; phase_d = phase_q; len_d = len_q;
    dec_d = dec_q; alld_d = alld_q; seed_d = seed_q; instr_d = instr_q;
    work_d = work_q; res_d = res_q; num_d = num_q;
    unique case (cmd_i.op)
      nmsh_pkg::OP_ABSORB: begin
        if (empty_string_i) begin
          hash_d = seed_i; seed_d = seed_i; part_d = '0; phase_d = '0;
          len_d = '0; dec_d = '0; alld_d = 1'b1; instr_d = 1'b0;
        end else begin
          if (!instr_q) begin
            seed_d = seed_i;
          end
          hash_d  = hash_b;
          instr_d = !last_byte_i;
          len_d   = len_b + 32'd1;
          alld_d  = alld_b & is_digit;
          dec_d   = is_digit ? ((dec_b << 3) + (dec_b << 1) +
                               {24'd0, data_byte_i - nmsh_pkg::AsciiZero})
                             : dec_b;
          if (phase_b == 2'd3) begin
            work_d  = {data_byte_i, part_b};
            part_d  = '0;
            phase_d = '0;
          end else begin
            work_d  = {8'd0, part_n};
            part_d  = part_n;
            phase_d = phase_b + 2'd1;
          end
        end
      end
      nmsh_pkg::OP_K1, nmsh_pkg::OP_K2, nmsh_pkg::OP_F1, nmsh_pkg::OP_F2: begin
        work_d = prod[31:0];
      end
      nmsh_pkg::OP_KMIX:  hash_d = (mix_t << 2) + mix_t + nmsh_pkg::MixAdd;
      nmsh_pkg::OP_KTAIL: hash_d = hash_q ^ work_q;
      nmsh_pkg::OP_RESULT: begin
        res_d = alld_q ? (dec_q + seed_q) : (work_q ^ (work_q >> 16));
        num_d = alld_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= '0;
      part_q  <= '0;
      phase_q <= '0;
      len_q   <= '0;
      dec_q   <= '0;
      alld_q  <= 1'b1;
      seed_q  <= '0;
      instr_q <= 1'b0;
    end else begin
      hash_q  <= hash_d;
      part_q  <= part_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      dec_q   <= dec_d;
      alld_q  <= alld_d;
      seed_q  <= seed_d;
      instr_q <= instr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    res_q  <= res_d;
    num_q  <= num_d;
  end

  assign hash_value_o = res_q;
  assign was_number_o = num_q;

endmodule

`default_nettype wire

// File: design/nmsh_ctrl.sv
`default_nettype none

module nmsh_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_last_i,
  input  wire               in_empty_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  nmsh_pkg::status_t status_i,
  output nmsh_pkg::cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_K1    = 8'b0000_0010,
    S_K2    = 8'b0000_0100,
    S_KMIX  = 8'b0000_1000,
    S_KTAIL = 8'b0001_0000,
    S_F1    = 8'b0010_0000,
    S_F2    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;   // string ends after the current block mix
  logic   tail_q, tail_d;   // scramble is for the tail bytes
  logic   ovld_q, ovld_d;
  logic   out_free;

  assign out_free   = !ovld_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    tail_d  = tail_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o.op = nmsh_pkg::OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = nmsh_pkg::OP_ABSORB;
          if (in_empty_i) begin
            state_d = S_DONE;
          end else if (status_i.block_done) begin
            if (in_last_i && status_i.digits_next) begin
              state_d = S_DONE;
            end else begin
              state_d = S_K1;
              tail_d  = 1'b0;
              pend_d  = in_last_i;
            end
          end else if (in_last_i) begin
            if (status_i.digits_next) begin
              state_d = S_DONE;
            end else begin
              state_d = S_K1;
              tail_d  = 1'b1;
              pend_d  = 1'b1;
            end
          end
        end
      end
      S_K1: begin
        cmd_o.op = nmsh_pkg::OP_K1;
        state_d  = S_K2;
      end
      S_K2: begin
        cmd_o.op = nmsh_pkg::OP_K2;
        state_d  = tail_q ? S_KTAIL : S_KMIX;
      end
      S_KMIX: begin
        cmd_o.op = nmsh_pkg::OP_KMIX;
        if (!pend_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = status_i.all_digits ? S_DONE : S_F1;
        end
      end
      S_KTAIL: begin
        cmd_o.op = nmsh_pkg::OP_KTAIL;
        state_d  = S_F1;
      end
      S_F1: begin
        cmd_o.op = nmsh_pkg::OP_F1;
        state_d  = S_F2;
      end
      S_F2: begin
        cmd_o.op = nmsh_pkg::OP_F2;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op = nmsh_pkg::OP_RESULT;
          ovld_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      tail_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      tail_q  <= tail_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

// File: design/numeric_or_murmur_string_hash_unit.sv
`default_nettype none

// Numeric-or-Murmur string hash. Strings arrive one byte per request on the
// slave stream, tlast on the final byte; a request with tuser[0] set is a whole
// empty string and its byte is ignored. The seed rides with every request but
// is sampled only on the first one of a string. One result per string leaves
// on the master stream: a MurmurHash3 x86_32 hash, or, when every byte was an
// ASCII digit, the decimal value plus the seed (mod 2^32), flagged by tuser[0].
// Steps: a byte that neither ends a string nor completes a 4-byte block is
// only accepted; one that completes a block mid-string is accepted, then C1
// and C2 go through the single shared 32x32 multiplier, then h1 is updated.
// A last byte on the decimal path, or an empty string, is accepted and then
// the result is loaded; block mixing is skipped there. A last byte on the hash
// path is accepted, then goes through either C1, C2 and the h1 update or C1,
// C2 and the tail fold, then two fmix multiply steps and the result load.
// The output register lets the slave side take the next string while a result
// waits; the core holds in its result step only if the previous result is
// still untaken.
module numeric_or_murmur_string_hash_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] seed
  input  wire         s_axis_tlast,   // last_byte
  input  wire  [0:0]  s_axis_tuser,   // [0] empty_string
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] hash_value
  output logic [0:0]  m_axis_tuser    // [0] was_number
);

  nmsh_pkg::cmd_t    cmd;
  nmsh_pkg::status_t status;
  logic              was_number;

  nmsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_empty_i  (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nmsh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .data_byte_i    (s_axis_tdata[7:0]),
    .last_byte_i    (s_axis_tlast),
    .empty_string_i (s_axis_tuser[0]),
    .seed_i         (s_axis_tdata[39:8]),
    .status_o       (status),
    .hash_value_o   (m_axis_tdata),
    .was_number_o   (was_number)
  );

  assign m_axis_tuser = was_number;

endmodule

`default_nettype wire
